### sv/dpbp_pkg.sv
// dpbp_pkg: shared types, constants and register codes for the depth pixel back-projection block
// no dependencies; used by every module under sv/ except dpbp_queue
package dpbp_pkg;

  // default geometry limits, handed down from the top level
  localparam int MAX_IMAGE_WIDTH_DEF  = 4096;
  localparam int MAX_IMAGE_HEIGHT_DEF = 4096;

  // fixed field widths
  localparam int DEPTH_W   = 16;
  localparam int COLOUR_W  = 24;
  localparam int INV_W     = 24;
  localparam int CENTRE_W  = 12;
  localparam int IWIDTH_W  = 13;
  localparam int OFFSET_W  = 16;   // covers column and row counters up to 65535
  localparam int POINT_W   = 32;
  localparam int Z_W       = 20;
  localparam int PROD1_W   = DEPTH_W + OFFSET_W;
  localparam int PROD2_W   = PROD1_W + INV_W;
  localparam int FRAC_SHIFT = 20;  // 1/16 mm scale against Q0.24

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_IMAGE_WIDTH = 3'd4
  } reg_index_t;

  localparam logic [INV_W-1:0]    INV_FOCAL_X_RST = 24'd32768;
  localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST = 24'd32768;
  localparam logic [CENTRE_W-1:0] CENTER_X_RST    = 12'd320;
  localparam logic [CENTRE_W-1:0] CENTER_Y_RST    = 12'd240;
  localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd640;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               frame_start;
  } pixel_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [Z_W-1:0]            point_z;
    logic [COLOUR_W-1:0]       packed_colour;
    logic                      point_valid;
  } point_t;

  typedef struct packed {
    logic [INV_W-1:0]    inverse_focal_x;
    logic [INV_W-1:0]    inverse_focal_y;
    logic [CENTRE_W-1:0] center_x;
    logic [CENTRE_W-1:0] center_y;
    logic [IWIDTH_W-1:0] image_width;
  } cfg_t;

  // one classified pixel, handed from front to back
  typedef struct packed {
    logic [DEPTH_W-1:0]  depth_mm;
    logic [COLOUR_W-1:0] colour;
    logic [OFFSET_W-1:0] offset_x;
    logic                neg_x;
    logic [OFFSET_W-1:0] offset_y;
    logic                neg_y;
  } job_t;

endpackage

### sv/dpbp_regs.sv
// dpbp_regs: APB-style configuration registers of the back-projection block
// depends on dpbp_pkg
module dpbp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpbp_pkg::ADDR_W-1:0] paddr,
  input  logic [dpbp_pkg::DATA_W-1:0] pwdata,
  output logic [dpbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dpbp_pkg::cfg_t              cfg
);

  dpbp_pkg::reg_index_t index;
  logic                 wr_en;

  assign index  = dpbp_pkg::reg_index_t'(paddr[dpbp_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_focal_x <= dpbp_pkg::INV_FOCAL_X_RST;
      cfg.inverse_focal_y <= dpbp_pkg::INV_FOCAL_Y_RST;
      cfg.center_x        <= dpbp_pkg::CENTER_X_RST;
      cfg.center_y        <= dpbp_pkg::CENTER_Y_RST;
      cfg.image_width     <= dpbp_pkg::IMAGE_WIDTH_RST;
    end else if (wr_en) begin
      unique case (index)
        dpbp_pkg::REG_INV_FOCAL_X: cfg.inverse_focal_x <= pwdata[dpbp_pkg::INV_W-1:0];
        dpbp_pkg::REG_INV_FOCAL_Y: cfg.inverse_focal_y <= pwdata[dpbp_pkg::INV_W-1:0];
        dpbp_pkg::REG_CENTER_X:    cfg.center_x        <= pwdata[dpbp_pkg::CENTRE_W-1:0];
        dpbp_pkg::REG_CENTER_Y:    cfg.center_y        <= pwdata[dpbp_pkg::CENTRE_W-1:0];
        dpbp_pkg::REG_IMAGE_WIDTH: cfg.image_width     <= pwdata[dpbp_pkg::IWIDTH_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (index)
      dpbp_pkg::REG_INV_FOCAL_X: prdata = dpbp_pkg::DATA_W'(cfg.inverse_focal_x);
      dpbp_pkg::REG_INV_FOCAL_Y: prdata = dpbp_pkg::DATA_W'(cfg.inverse_focal_y);
      dpbp_pkg::REG_CENTER_X:    prdata = dpbp_pkg::DATA_W'(cfg.center_x);
      dpbp_pkg::REG_CENTER_Y:    prdata = dpbp_pkg::DATA_W'(cfg.center_y);
      dpbp_pkg::REG_IMAGE_WIDTH: prdata = dpbp_pkg::DATA_W'(cfg.image_width);
      default:                   prdata = '0;
    endcase
  end

endmodule

### sv/dpbp_queue.sv
// dpbp_queue: small first-in first-out queue used between front and back and at the output
// depends on nothing but its type parameter
module dpbp_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !empty)
    else $error("pushed entry not visible");

  a_pop_lone_last: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == CW'(1)) |=> empty)
    else $error("last entry not removed");

endmodule

### sv/dpbp_front.sv
// dpbp_front: pixel position counters and offset classification ahead of the arithmetic
// depends on dpbp_pkg
module dpbp_front #(
  parameter int MAX_IMAGE_WIDTH  = dpbp_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = dpbp_pkg::MAX_IMAGE_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  dpbp_pkg::pixel_t pixel,
  input  dpbp_pkg::cfg_t   cfg,
  output logic             job_push,
  output dpbp_pkg::job_t   job,
  input  logic             job_full
);

  localparam int CW = $clog2(MAX_IMAGE_WIDTH);
  localparam int EW = CW + 1;
  localparam int RW = $clog2(MAX_IMAGE_HEIGHT);
  localparam int OW = dpbp_pkg::OFFSET_W;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] column_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [EW-1:0] eff_width;
  logic [EW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          col_wrap;
  logic          row_wrap;
  logic [OW-1:0] u_ext;
  logic [OW-1:0] v_ext;
  logic [OW-1:0] cx_ext;
  logic [OW-1:0] cy_ext;

  assign full     = job_full;
  assign job_push = push && !job_full;

  always_comb begin
    if (cfg.image_width == '0) begin
      eff_width = EW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_IMAGE_WIDTH)) begin
      eff_width = EW'(MAX_IMAGE_WIDTH);
    end else begin
      eff_width = EW'(cfg.image_width);
    end
  end

  // frame start clears the position before this pixel uses it
  assign col_pos = pixel.frame_start ? '0 : column_count;
  assign row_pos = pixel.frame_start ? '0 : row_count;

  assign col_inc  = {1'b0, col_pos} + EW'(1);
  assign col_wrap = (col_inc >= eff_width);
  assign row_inc  = {1'b0, row_pos} + (RW + 1)'(1);
  assign row_wrap = (row_inc >= (RW + 1)'(MAX_IMAGE_HEIGHT));

  assign column_next = col_wrap ? '0 : col_inc[CW-1:0];
  assign row_next    = !col_wrap ? row_pos : (row_wrap ? '0 : row_inc[RW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (job_push) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  assign u_ext  = OW'(col_pos);
  assign v_ext  = OW'(row_pos);
  assign cx_ext = OW'(cfg.center_x);
  assign cy_ext = OW'(cfg.center_y);

  always_comb begin
    job.depth_mm = pixel.depth_mm;
    job.colour   = {pixel.red, pixel.green, pixel.blue};
    job.neg_x    = (u_ext < cx_ext);
    job.offset_x = job.neg_x ? (cx_ext - u_ext) : (u_ext - cx_ext);
    job.neg_y    = (v_ext < cy_ext);
    job.offset_y = job.neg_y ? (cy_ext - v_ext) : (v_ext - cy_ext);
  end

endmodule

### sv/dpbp_back.sv
// dpbp_back: three-stage multiply, round and saturate pipeline of the back-projection
// depends on dpbp_pkg
module dpbp_back (
  input  logic             clk,
  input  logic             rst,
  input  dpbp_pkg::job_t   job,
  input  logic             job_empty,
  output logic             job_pop,
  input  dpbp_pkg::cfg_t   cfg,
  output logic             res_push,
  output dpbp_pkg::point_t res,
  input  logic             res_full
);

  localparam int P1 = dpbp_pkg::PROD1_W;
  localparam int P2 = dpbp_pkg::PROD2_W;
  localparam int RSW = P2 + 1;
  localparam int PW = dpbp_pkg::POINT_W;

  typedef struct packed {
    logic [dpbp_pkg::DEPTH_W-1:0]  depth_mm;
    logic [dpbp_pkg::COLOUR_W-1:0] colour;
    logic                          neg_x;
    logic                          neg_y;
  } side_t;

  logic          en;
  logic          s1_valid;
  logic          s2_valid;
  logic          s3_valid;
  side_t         s1_side;
  side_t         s2_side;
  logic [P1-1:0] s1_prod_x;
  logic [P1-1:0] s1_prod_y;
  logic [P2-1:0] s2_mag_x;
  logic [P2-1:0] s2_mag_y;

  // round half away from zero on the magnitude, then clamp to 32-bit signed
  function automatic logic signed [PW-1:0] round_sat(input logic [P2-1:0] mag,
                                                     input logic          neg);
    logic [RSW-1:0]              sum;
    logic [RSW-dpbp_pkg::FRAC_SHIFT-1:0] r;
    logic signed [PW-1:0]        value;
    sum = {1'b0, mag} + (RSW'(1) << (dpbp_pkg::FRAC_SHIFT - 1));
    r   = sum[RSW-1:dpbp_pkg::FRAC_SHIFT];
    if (neg) begin
      if (r >= (RSW - dpbp_pkg::FRAC_SHIFT)'(33'h0_8000_0000)) begin
        value = {1'b1, {(PW-1){1'b0}}};
      end else begin
        value = -$signed(r[PW-1:0]);
      end
    end else begin
      if (r > (RSW - dpbp_pkg::FRAC_SHIFT)'(33'h0_7FFF_FFFF)) begin
        value = {1'b0, {(PW-1){1'b1}}};
      end else begin
        value = $signed(r[PW-1:0]);
      end
    end
    return value;
  endfunction

  assign en       = !res_full;
  assign job_pop  = en && !job_empty;
  assign res_push = en && s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= !job_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // depth times offset
      s1_side.depth_mm <= job.depth_mm;
      s1_side.colour   <= job.colour;
      s1_side.neg_x    <= job.neg_x;
      s1_side.neg_y    <= job.neg_y;
      s1_prod_x <= P1'(job.depth_mm) * P1'(job.offset_x);
      s1_prod_y <= P1'(job.depth_mm) * P1'(job.offset_y);
      // times inverse focal length
      s2_side  <= s1_side;
      s2_mag_x <= P2'(s1_prod_x) * P2'(cfg.inverse_focal_x);
      s2_mag_y <= P2'(s1_prod_y) * P2'(cfg.inverse_focal_y);
      // scale, round, saturate, and blank on zero depth
      res.packed_colour <= s2_side.colour;
      if (s2_side.depth_mm == '0) begin
        res.point_x     <= '0;
        res.point_y     <= '0;
        res.point_z     <= '0;
        res.point_valid <= 1'b0;
      end else begin
        res.point_x     <= round_sat(s2_mag_x, s2_side.neg_x);
        res.point_y     <= round_sat(s2_mag_y, s2_side.neg_y);
        res.point_z     <= {s2_side.depth_mm, 4'b0000};
        res.point_valid <= 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_valid_has_depth: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.point_valid) |-> (res.point_z != '0))
    else $error("valid point with zero depth");

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> s1_valid)
    else $error("popped job lost before first stage");

endmodule

### sv/depth_pixel_back_projection.sv
// depth_pixel_back_projection: top level, pinhole back-projection of a depth and colour stream
// depends on dpbp_pkg, dpbp_regs, dpbp_queue, dpbp_front, dpbp_back
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   pixel    | in        | push / full          | dpbp_pkg::pixel_t
//   point    | out       | pop / empty          | dpbp_pkg::point_t
//   config   | in        | psel/penable/pwrite  | paddr, pwdata, prdata
//
// one pixel is taken per clock and one point delivered per clock when nothing stalls
// an accepted pixel is registered in the job queue, then in each stage of the multiply/round
//   pipeline, and then in the result queue, at whose head the point shows
// rst (synchronous) clears the counters, restores register defaults and empties both queues
// a stalled result side fills the result queue, then freezes the pipeline, then the job queue,
//   and only then raises full; no pixel is dropped and none is repeated
module depth_pixel_back_projection #(
  parameter int MAX_IMAGE_WIDTH  = dpbp_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int MAX_IMAGE_HEIGHT = dpbp_pkg::MAX_IMAGE_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel stream
  input  logic                        push,
  output logic                        full,
  input  dpbp_pkg::pixel_t            pixel,
  // point stream
  output logic                        empty,
  input  logic                        pop,
  output dpbp_pkg::point_t            point,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpbp_pkg::ADDR_W-1:0] paddr,
  input  logic [dpbp_pkg::DATA_W-1:0] pwdata,
  output logic [dpbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  dpbp_pkg::cfg_t   cfg;
  dpbp_pkg::job_t   front_job;
  dpbp_pkg::job_t   back_job;
  dpbp_pkg::point_t back_res;
  logic             job_push;
  logic             job_full;
  logic             job_pop;
  logic             job_empty;
  logic             res_push;
  logic             res_full;

  // register file; the user must write it only while the block is quiet, the block does not enforce this
  dpbp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: position counters and signed offsets from the principal point
  dpbp_front #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .pixel    (pixel),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (front_job),
    .job_full (job_full)
  );

  // decoupling queue between front and back
  dpbp_queue #(
    .T     (dpbp_pkg::job_t),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (front_job),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (back_job),
    .empty (job_empty)
  );

  // back: multiply, round and saturate
  dpbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .cfg       (cfg),
    .res_push  (res_push),
    .res       (back_res),
    .res_full  (res_full)
  );

  // result queue, parts the pipeline from the consumer
  dpbp_queue #(
    .T     (dpbp_pkg::point_t),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (point),
    .empty (empty)
  );

endmodule
